// File: design/csb_pkg.sv
package csb_pkg;

  // Default sizing of the block; the top level hands these down as parameters.
  localparam int DEF_MAX_DIM    = 2048;
  localparam int DEF_MAX_FRAMES = 256;

  // Depth of the queue between the front and back parts (a power of two).
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_NUMBER = 3'd6;

  localparam int CFG_DATA_W = 12;

  // Configuration as held by the block: dimensions and frame number are
  // stored already saturated, so every consumer sees the effective values.
  typedef struct packed {
    logic [11:0]        dw;
    logic [11:0]        dh;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [11:0]        fw;
    logic [11:0]        fh;
    logic [7:0]         fn;
  } cfg_t;

  // One classified texel, as passed from the front part to the back part.
  typedef struct packed {
    logic       we;
    logic       on_screen;
    logic       opaque;
    logic       last;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0] tb;
    logic [7:0] tg;
    logic [7:0] tr;
    logic [7:0] ta;
    logic [7:0] db;
    logic [7:0] dg;
    logic [7:0] dr;
    logic [7:0] da;
  } item_t;

endpackage

// File: design/csb_front.sv
module csb_front #(
  parameter int MAX_DIM = csb_pkg::DEF_MAX_DIM
) (
  input  logic           clk,
  input  logic           rst,
  input  csb_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     tex_blue,
  input  logic [7:0]     tex_green,
  input  logic [7:0]     tex_red,
  input  logic [7:0]     tex_alpha,
  input  logic [7:0]     dst_blue,
  input  logic [7:0]     dst_green,
  input  logic [7:0]     dst_red,
  input  logic [7:0]     dst_alpha,
  input  logic           full,
  output logic           push,
  output csb_pkg::item_t item
);
  import csb_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);

  logic [CNT_W-1:0] col, row, col_next, row_next;
  logic [13:0]      sx, sy;
  logic             col_end, row_end, last, on_screen, accept;

  assign accept   = in_valid && !full;
  assign in_stall = full;
  assign push     = accept;

  // Screen position of the current texel; bit 13 is the sign.
  assign sx = {{2{cfg.pos_x[11]}}, cfg.pos_x} + 14'(col);
  assign sy = {{2{cfg.pos_y[11]}}, cfg.pos_y} + 14'(row);

  assign on_screen = !sx[13] && !sy[13] &&
                     (sx[12:0] < {1'b0, cfg.dw}) && (sy[12:0] < {1'b0, cfg.dh});

  assign col_end = (13'(col) + 13'd1) >= {1'b0, cfg.fw};
  assign row_end = (13'(row) + 13'd1) >= {1'b0, cfg.fh};
  assign last    = col_end && row_end;

  always_comb begin
    item           = '0;
    item.on_screen = on_screen;
    item.we        = on_screen && (tex_alpha != 8'd0);
    item.opaque    = tex_alpha == 8'd255;
    item.last      = last;
    item.sx        = on_screen ? sx[11:0] : 12'd0;
    item.sy        = on_screen ? sy[11:0] : 12'd0;
    item.col       = 12'(col);
    item.row       = 12'(row);
    item.tb        = tex_blue;
    item.tg        = tex_green;
    item.tr        = tex_red;
    item.ta        = tex_alpha;
    item.db        = dst_blue;
    item.dg        = dst_green;
    item.dr        = dst_red;
    item.da        = dst_alpha;
  end

  always_comb begin
    col_next = col + 1'b1;
    row_next = row;
    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_end) begin
      col_next = '0;
      row_next = row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  a_scan_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> (col == '0) && (row == '0))
    else $error("scan did not return to the origin after the last texel");

  a_col_steps: assert property (@(posedge clk) disable iff (rst)
    accept && !col_end |=> col == $past(col) + 1'b1)
    else $error("column counter did not advance");

endmodule

// File: design/csb_queue.sv
module csb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csb_pkg::item_t wr_item,
  input  logic           pop,
  output csb_pkg::item_t head,
  output logic           full,
  output logic           empty
);
  import csb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("read from an empty queue");

endmodule

// File: design/csb_back.sv
module csb_back (
  input  logic           clk,
  input  logic           rst,
  input  csb_pkg::cfg_t  cfg,
  input  logic           empty,
  input  csb_pkg::item_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           write_enable,
  output logic [21:0]    dest_index,
  output logic [23:0]    src_index,
  output logic [7:0]     out_blue,
  output logic [7:0]     out_green,
  output logic [7:0]     out_red,
  output logic [7:0]     out_alpha,
  output logic           last_of_blit
);
  import csb_pkg::*;

  function automatic logic signed [17:0] blend_product(input logic [7:0] s,
                                                       input logic [7:0] d,
                                                       input logic [7:0] a);
    logic signed [8:0] diff;
    logic signed [8:0] wa;
    diff = $signed({1'b0, s}) - $signed({1'b0, d});
    wa   = $signed({1'b0, a});
    return 18'(wa) * 18'(diff);
  endfunction

  // Floor division by 256 is an arithmetic shift; the sum wraps to a byte.
  function automatic logic [7:0] blend_finish(input logic [7:0] d,
                                              input logic signed [17:0] p);
    logic signed [17:0] q;
    q = p >>> 8;
    return d + q[7:0];
  endfunction

  logic advance;

  // Stage 1: products.
  logic               s1_valid;
  item_t              s1_item;
  logic [23:0]        s1_dest_prod, s1_row_prod, s1_frame_prod;
  logic signed [17:0] s1_pb, s1_pg, s1_pr;

  // Stage 2: sums, frame base and finished colours.
  logic        s2_valid, s2_we, s2_last;
  logic [21:0] s2_dest;
  logic [23:0] s2_src_part, s2_base;
  logic [7:0]  s2_b, s2_g, s2_r, s2_a;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !empty;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item       <= head;
      s1_dest_prod  <= 24'(head.sy) * 24'(cfg.dw);
      s1_row_prod   <= 24'(head.row) * 24'(cfg.fw);
      s1_frame_prod <= 24'(cfg.fw) * 24'(cfg.fh);
      s1_pb         <= blend_product(head.tb, head.db, head.ta);
      s1_pg         <= blend_product(head.tg, head.dg, head.ta);
      s1_pr         <= blend_product(head.tr, head.dr, head.ta);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_we       <= s1_item.we;
      s2_last     <= s1_item.last;
      s2_dest     <= s1_item.on_screen ? 22'(s1_dest_prod + 24'(s1_item.sx)) : 22'd0;
      s2_src_part <= s1_row_prod + 24'(s1_item.col);
      s2_base     <= s1_frame_prod * 24'(cfg.fn);
      if (!s1_item.we) begin
        s2_b <= s1_item.db;
        s2_g <= s1_item.dg;
        s2_r <= s1_item.dr;
        s2_a <= s1_item.da;
      end else if (s1_item.opaque) begin
        s2_b <= s1_item.tb;
        s2_g <= s1_item.tg;
        s2_r <= s1_item.tr;
        s2_a <= s1_item.ta;
      end else begin
        s2_b <= blend_finish(s1_item.db, s1_pb);
        s2_g <= blend_finish(s1_item.dg, s1_pg);
        s2_r <= blend_finish(s1_item.dr, s1_pr);
        s2_a <= s1_item.da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_enable <= s2_we;
      last_of_blit <= s2_last;
      dest_index   <= s2_dest;
      src_index    <= s2_src_part + s2_base;
      out_blue     <= s2_b;
      out_green    <= s2_g;
      out_red      <= s2_r;
      out_alpha    <= s2_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  a_pop_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_valid)
    else $error("item taken from the queue was lost");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && s2_valid |=> s2_valid && out_valid)
    else $error("pipeline moved while the output was stalled");

endmodule

// File: design/clipped_alpha_sprite_blit.sv
// Clipped alpha sprite blitter. Texels of the selected animation frame are
// presented in raster order, each with the destination pixel at its screen
// position, and the block returns one result per texel: a write enable, the
// destination pixel index, the source texel index and the pixel to write.
// The block sustains one texel per clock cycle while the queue is not full;
// each result passes through the queue and then the three-stage arithmetic
// pipeline (index multiplies, then frame base multiply and blend, then the
// final index sum). A four-entry queue separates scan tracking from the
// arithmetic, so input transfers continue while the output is stalled until
// the queue fills. Configuration is written through its own port, which is
// always ready, and must only be written while no texel is in flight.
module clipped_alpha_sprite_blit #(
  parameter int MAX_DIM    = csb_pkg::DEF_MAX_DIM,
  parameter int MAX_FRAMES = csb_pkg::DEF_MAX_FRAMES
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  // Texel input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  tex_blue,
  input  logic [7:0]  tex_green,
  input  logic [7:0]  tex_red,
  input  logic [7:0]  tex_alpha,
  input  logic [7:0]  dst_blue,
  input  logic [7:0]  dst_green,
  input  logic [7:0]  dst_red,
  input  logic [7:0]  dst_alpha,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_enable,
  output logic [21:0] dest_index,
  output logic [23:0] src_index,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_alpha,
  output logic        last_of_blit
);
  import csb_pkg::*;

  // Effective dimension: a zero value takes the given substitute, and
  // anything above the supported maximum is clamped to it.
  function automatic logic [11:0] sat_dim(input logic [11:0] v,
                                          input logic [11:0] zero_as);
    logic [11:0] r;
    r = v;
    if (v == 12'd0) begin
      r = zero_as;
    end else if ({1'b0, v} > 13'(MAX_DIM)) begin
      r = 12'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_frame(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if ({3'b000, v} >= 11'(MAX_FRAMES)) begin
      r = 8'(MAX_FRAMES - 1);
    end
    return r;
  endfunction

  cfg_t  cfg;
  item_t q_wr_item, q_head;
  logic  q_push, q_pop, q_full, q_empty;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  // The registers hold effective values: saturation is applied as each
  // register is written, so the datapath never has to repeat it. A write to
  // an index beyond the register list is accepted and has no effect.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dw    <= 12'd640;
      cfg.dh    <= 12'd480;
      cfg.pos_x <= 12'sd0;
      cfg.pos_y <= 12'sd0;
      cfg.fw    <= 12'd64;
      cfg.fh    <= 12'd64;
      cfg.fn    <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEST_WIDTH:   cfg.dw    <= sat_dim(cfg_data, 12'd0);
        CFG_DEST_HEIGHT:  cfg.dh    <= sat_dim(cfg_data, 12'd0);
        CFG_POS_X:        cfg.pos_x <= $signed(cfg_data);
        CFG_POS_Y:        cfg.pos_y <= $signed(cfg_data);
        CFG_FRAME_WIDTH:  cfg.fw    <= sat_dim(cfg_data, 12'd1);
        CFG_FRAME_HEIGHT: cfg.fh    <= sat_dim(cfg_data, 12'd1);
        CFG_FRAME_NUMBER: cfg.fn    <= sat_frame(cfg_data[7:0]);
        default:          cfg.fn    <= cfg.fn;
      endcase
    end
  end

  // Front part: tracks the scan position, clips against the destination
  // surface and classifies each texel as skipped, copied or blended.
  csb_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tex_blue  (tex_blue),
    .tex_green (tex_green),
    .tex_red   (tex_red),
    .tex_alpha (tex_alpha),
    .dst_blue  (dst_blue),
    .dst_green (dst_green),
    .dst_red   (dst_red),
    .dst_alpha (dst_alpha),
    .full      (q_full),
    .push      (q_push),
    .item      (q_wr_item)
  );

  // Short queue that lets the front keep taking texels while the result
  // side is held up.
  csb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .head    (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back part: index arithmetic and colour blending, ending in the output
  // register that holds a result until it is transferred.
  csb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .empty        (q_empty),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_enable (write_enable),
    .dest_index   (dest_index),
    .src_index    (src_index),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red),
    .out_alpha    (out_alpha),
    .last_of_blit (last_of_blit)
  );

endmodule

// File: verif/blit_checker.sv
`timescale 1ns / 1ps
module blit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  tex_blue,
  input  logic [7:0]  tex_green,
  input  logic [7:0]  tex_red,
  input  logic [7:0]  tex_alpha,
  input  logic [7:0]  dst_blue,
  input  logic [7:0]  dst_green,
  input  logic [7:0]  dst_red,
  input  logic [7:0]  dst_alpha,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        write_enable,
  input  logic [21:0] dest_index,
  input  logic [23:0] src_index,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_alpha,
  input  logic        last_of_blit,
  output int          mismatches,
  output int          awaited
);
  import csb_pkg::*;

  typedef struct packed {
    logic        we;
    logic [21:0] didx;
    logic [23:0] sidx;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    logic [7:0]  a;
    logic        last;
  } pixel_write_t;

  logic [11:0]        reg_dw, reg_dh, reg_fw, reg_fh;
  logic signed [11:0] reg_px, reg_py;
  logic [7:0]         reg_fn;
  longint             scan_col, scan_row;

  pixel_write_t pending_pixels[$];
  int fault_count = 0;
  int queue_depth = 0;

  assign mismatches = fault_count;
  assign awaited    = queue_depth;

  function automatic longint eff_dim(input logic [11:0] v, input longint zero_as);
    if (v == 12'd0) return zero_as;
    if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
    return v;
  endfunction

  // d + floor(a * (s - d) / 256), the shift being arithmetic.
  function automatic logic [7:0] blend_channel(input logic [7:0] s, d, a);
    int p;
    p = int'(a) * (int'(s) - int'(d));
    return 8'(int'(d) + (p >>> 8));
  endfunction

  function automatic pixel_write_t blit_texel(input logic [7:0] sb, sg, sr, sa,
                                              input logic [7:0] db, dg, dr, da);
    longint dw, dh, fw, fh, fn, sx, sy;
    logic in_bounds, col_end;
    pixel_write_t res;
    dw = eff_dim(reg_dw, 0);
    dh = eff_dim(reg_dh, 0);
    fw = eff_dim(reg_fw, 1);
    fh = eff_dim(reg_fh, 1);
    fn = (reg_fn > DEF_MAX_FRAMES - 1) ? DEF_MAX_FRAMES - 1 : reg_fn;
    sx = longint'(reg_px) + scan_col;
    sy = longint'(reg_py) + scan_row;
    in_bounds = sx >= 0 && sy >= 0 && sx < dw && sy < dh;
    res.we   = in_bounds && sa != 8'd0;
    res.didx = in_bounds ? 22'(sy * dw + sx) : 22'd0;
    res.sidx = 24'(scan_col + scan_row * fw + fw * fh * fn);
    {res.b, res.g, res.r, res.a} = {db, dg, dr, da};
    if (res.we && sa == 8'hff) begin
      {res.b, res.g, res.r, res.a} = {sb, sg, sr, sa};
    end else if (res.we) begin
      res.b = blend_channel(sb, db, sa);
      res.g = blend_channel(sg, dg, sa);
      res.r = blend_channel(sr, dr, sa);
    end
    // A counter left beyond a newly shrunk frame ends its line or frame at once.
    col_end  = scan_col + 1 >= fw;
    res.last = col_end && scan_row + 1 >= fh;
    if (res.last) begin
      scan_col = 0;
      scan_row = 0;
    end else if (col_end) begin
      scan_col = 0;
      scan_row++;
    end else begin
      scan_col++;
    end
    return res;
  endfunction

  task automatic flag(input string what, input pixel_write_t want, got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected we=%0b dest=%0d src=%0d bgra=%h_%h_%h_%h last=%0b",
               what, want.we, want.didx, want.sidx, want.b, want.g, want.r, want.a,
               want.last);
      $display("  got we=%0b dest=%0d src=%0d bgra=%h_%h_%h_%h last=%0b",
               got.we, got.didx, got.sidx, got.b, got.g, got.r, got.a, got.last);
    end
  endtask

  always @(posedge clk) begin
    pixel_write_t got, want;
    if (rst) begin
      reg_dw   = 12'd640;
      reg_dh   = 12'd480;
      reg_px   = 12'sd0;
      reg_py   = 12'sd0;
      reg_fw   = 12'd64;
      reg_fh   = 12'd64;
      reg_fn   = 8'd0;
      scan_col = 0;
      scan_row = 0;
      pending_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEST_WIDTH:   reg_dw = cfg_data;
          CFG_DEST_HEIGHT:  reg_dh = cfg_data;
          CFG_POS_X:        reg_px = cfg_data;
          CFG_POS_Y:        reg_py = cfg_data;
          CFG_FRAME_WIDTH:  reg_fw = cfg_data;
          CFG_FRAME_HEIGHT: reg_fh = cfg_data;
          CFG_FRAME_NUMBER: reg_fn = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {write_enable, dest_index, src_index, out_blue, out_green, out_red,
               out_alpha, last_of_blit};
        if (pending_pixels.size() == 0) begin
          flag("blit_check: result with nothing outstanding", '0, got);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) flag("blit_check: result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        pending_pixels.push_back(blit_texel(tex_blue, tex_green, tex_red, tex_alpha,
                                            dst_blue, dst_green, dst_red, dst_alpha));
      end
    end
    queue_depth <= pending_pixels.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Top level of the blitter testbench. This module only generates stimulus and
// gives the verdict; the checker instantiated beside the block watches every
// transfer, predicts each result and compares.
module tb;
  import csb_pkg::*;

  // There are seven registers, so index seven must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETUPS          = 21;
  localparam int ITEMS_PER_SETUP = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  tex_blue = '0, tex_green = '0, tex_red = '0, tex_alpha = '0;
  logic [7:0]  dst_blue = '0, dst_green = '0, dst_red = '0, dst_alpha = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        write_enable;
  logic [21:0] dest_index;
  logic [23:0] src_index;
  logic [7:0]  out_blue, out_green, out_red, out_alpha;
  logic        last_of_blit;

  int mismatches;
  int awaited;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls; the stimulus changes them as the run moves between its sections.
  int send_idle_pct = 6;
  int stall_pct     = 86;
  int quiet_cycles  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  clipped_alpha_sprite_blit DUT (.*);

  blit_checker blit_check (.*);

  // The receiver decides afresh on every cycle whether it can take a result.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any transfer on any channel counts as progress. The pauses the
  // stimulus takes on purpose are far shorter than QUIET_LIMIT.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one texel and holds it until the block takes it. The valid is
  // left high afterwards, so that back-to-back texels follow without a gap;
  // whoever comes next either drives a new texel or lowers it.
  task automatic send_texel(input logic [7:0] sb, sg, sr, sa,
                            input logic [7:0] db, dg, dr, da);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    tex_blue  <= sb;
    tex_green <= sg;
    tex_red   <= sr;
    tex_alpha <= sa;
    dst_blue  <= db;
    dst_green <= dg;
    dst_red   <= dr;
    dst_alpha <= da;
    do @(posedge clk); while (in_stall);
  endtask

  // Random texel. Transparent and opaque texels are favoured, as they take
  // their own paths through the block; the rest are blended.
  task automatic send_random();
    logic [7:0] alpha;
    case ($urandom_range(4))
      0:       alpha = 8'h00;
      1:       alpha = 8'hff;
      default: alpha = 8'($urandom);
    endcase
    send_texel(8'($urandom), 8'($urandom), 8'($urandom), alpha,
               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stops sending and waits until every result has come back, then keeps
  // waiting so that the three-stage pipeline empties completely.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (8) @(posedge clk);
  endtask

  // One register write. The valid stays high so that a series of writes
  // follows on without gaps; load_setup lowers it at the end.
  task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setup(input logic [11:0] dw, dh, px, py, fw, fh,
                            input logic [7:0] fn, input bit poke_unused);
    write_reg(CFG_DEST_WIDTH, dw);
    write_reg(CFG_DEST_HEIGHT, dh);
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_FRAME_NUMBER, {4'd0, fn});
    if (poke_unused) write_reg(CFG_UNUSED, 12'($urandom));
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Sizes are mostly small so that frames finish often and clipping happens
  // on every edge; now and then a zero, the maximum or an oversized value.
  function automatic logic [11:0] pick_size(input int small_max);
    case ($urandom_range(15))
      0:       return 12'd0;
      1:       return 12'd2048;
      2:       return 12'(4095 - $urandom_range(2046));
      3:       return 12'($urandom);
      default: return 12'($urandom_range(small_max, 1));
    endcase
  endfunction

  // Positions hover round the top-left corner, reaching a little off-screen.
  function automatic logic [11:0] pick_pos();
    case ($urandom_range(11))
      0:       return 12'h800;
      1:       return 12'h7ff;
      2:       return 12'($urandom);
      default: return 12'($urandom_range(14) - 4);
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed section, run on the reset setting first: a transparent texel,
    // a full copy, a faint texel darkening a bright pixel (rounding towards
    // minus infinity), a half blend, and alternating bit patterns.
    send_texel(8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff);
    send_texel(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
    send_texel(8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff);
    send_texel(8'hff, 8'hff, 8'hff, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00);
    send_texel(8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa, 8'h55, 8'haa);
    send_texel(8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55, 8'haa, 8'h55);
    send_texel(8'h12, 8'h34, 8'h56, 8'hfe, 8'h9a, 8'hbc, 8'hde, 8'hf0);
    send_texel(8'h80, 8'h7f, 8'h01, 8'hff, 8'h3c, 8'hc3, 8'h0f, 8'hf0);
    drain();

    // A two-by-two frame of the top animation frame, hanging off the top-left
    // of a three-by-three surface. The scan stands at column eight, beyond
    // the new frame width, so it has to wrap. Index seven is written as well
    // and must change nothing.
    load_setup(12'd3, 12'd3, 12'hfff, 12'hfff, 12'd2, 12'd2, 8'd255, 1'b1);
    repeat (6) send_random();
    drain();

    // Zero sizes: a zero destination clips everything and a zero frame scans
    // as a single texel. The height is oversized and the positions extreme.
    load_setup(12'd0, 12'd4095, 12'h7ff, 12'h800, 12'd0, 12'd0, 8'd0, 1'b0);
    repeat (3) send_random();
    drain();

    // Largest surface with the sprite at its bottom-right pixel, giving the
    // highest destination index, and a frame base that overflows the source
    // index.
    load_setup(12'd2048, 12'd2048, 12'h7ff, 12'h7ff, 12'd4095, 12'd2048, 8'd255,
               1'b0);
    repeat (3) send_random();
    drain();

    // Random section in three parts: a slow receiver, then a slow sender,
    // then neither holding back. Every setting change waits for the block to
    // run dry, since registers may only be written with nothing in flight.
    for (int s = 0; s < SETUPS; s++) begin
      if (s == SETUPS / 3) begin
        send_idle_pct = 86;
        stall_pct     = 6;
      end else if (s == 2 * SETUPS / 3) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      load_setup(pick_size(12), pick_size(10), pick_pos(), pick_pos(),
                 pick_size(8), pick_size(6), 8'($urandom), $urandom_range(2) == 0);
      repeat (ITEMS_PER_SETUP) send_random();
      drain();
    end

    if (mismatches == 0 && awaited == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/csb_pkg.sv
design/csb_front.sv
design/csb_queue.sv
design/csb_back.sv
design/clipped_alpha_sprite_blit.sv
verif/blit_checker.sv
verif/tb.sv
